[hw/rtl/ceq_pkg.sv]
// Package for the coalescing event queue: action codes, entry and payload types.
// No dependencies; used by coalescing_event_queue_unit.
package ceq_pkg;

  localparam logic [1:0] ACT_ARRIVE   = 2'd0;
  localparam logic [1:0] ACT_REGISTER = 2'd1;
  localparam logic [1:0] ACT_DRAIN    = 2'd2;

  localparam int unsigned COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] event_number;
    logic       enable;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_event;
    logic [COUNT_W-1:0] occurrences;
    logic               fire;
    logic               last;
  } out_t;

  // one entry of the per-event memory
  typedef struct packed {
    logic               enabled;
    logic [COUNT_W-1:0] count;
  } ev_entry_t;

endpackage

[hw/rtl/coalescing_event_queue_unit.sv]
// Coalescing pending-event queue: per-event count/enable memory and arrival-order FIFO memory.
// Depends on ceq_pkg.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one transaction per action:
//   arrive counts an enabled event and queues its number on first occurrence, register
//   sets or clears an event's enable and zeroes its count, drain walks the queue.
//   result channel (result_valid/result_ready/result) gives one transaction per
//   queue entry visited by a drain; last marks the final one of the run.
// Sequencing:
//   register writes the event memory directly. arrive reads the event memory,
//   then writes it back. drain reads the queue, then the event memory, for each
//   queue entry; both memories have registered reads and the block handles one
//   transaction at a time. A drain of an empty queue gives no result.
// Reset: per-entry valid bits clear at once, so every count and enable reads as
//   zero right after reset; the queue is empty. No clearing pass is needed.
// Stall: results go through a single output register. A new item is taken while
//   a result waits; a drain stops walking while a result waits and result_ready is low.
module coalescing_event_queue_unit #(
  parameter int unsigned NUM_EVENTS  = 256,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ceq_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_ready,
  output ceq_pkg::out_t  result
);

  localparam int unsigned EV_W  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned Q_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_ARRIVE   = 4'b0010,
    S_DRN_RD   = 4'b0100,
    S_DRN_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // event memory with valid bits
  ceq_pkg::ev_entry_t ev_mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] ev_vld;
  logic                  ev_re, ev_we;
  logic [EV_W-1:0]       ev_raddr, ev_waddr;
  ceq_pkg::ev_entry_t    ev_wdata, ev_rdata;
  logic                  ev_rvld;
  ceq_pkg::ev_entry_t    ev_cur;

  // queue memory
  logic [7:0]       q_mem [QUEUE_DEPTH];
  logic             q_re, q_we;
  logic [Q_AW-1:0]  q_raddr;
  logic [7:0]       q_rdata;

  logic [LEN_W-1:0] fifo_length, fifo_length_next;
  logic [LEN_W-1:0] drain_idx, drain_idx_next;
  logic [7:0]       cur_ev, cur_ev_next;

  logic in_fire, in_range, slot_free, drn_last, emit;

  assign item_ready = (state == S_IDLE);
  assign in_fire    = item_valid && item_ready;
  assign in_range   = ({1'b0, item.event_number} < 9'(NUM_EVENTS));
  assign slot_free  = !result_valid || result_ready;
  assign drn_last   = ((drain_idx + LEN_W'(1)) == fifo_length);
  assign emit       = (state == S_DRN_EMIT) && slot_free;
  assign ev_cur     = ev_rvld ? ev_rdata : '0;

  always_comb begin
    state_next       = state;
    fifo_length_next = fifo_length;
    drain_idx_next   = drain_idx;
    cur_ev_next      = cur_ev;
    ev_re            = 1'b0;
    ev_raddr         = item.event_number[EV_W-1:0];
    ev_we            = 1'b0;
    ev_waddr         = cur_ev[EV_W-1:0];
    ev_wdata         = ev_cur;
    q_re             = 1'b0;
    q_raddr          = drain_idx[Q_AW-1:0];
    q_we             = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cur_ev_next = item.event_number;
          case (item.action)
            ceq_pkg::ACT_ARRIVE: begin
              if (in_range) begin
                ev_re      = 1'b1;
                state_next = S_ARRIVE;
              end
            end
            ceq_pkg::ACT_REGISTER: begin
              if (in_range) begin
                ev_we    = 1'b1;
                ev_waddr = item.event_number[EV_W-1:0];
                ev_wdata = '{enabled: item.enable, count: '0};
              end
            end
            ceq_pkg::ACT_DRAIN: begin
              if (fifo_length != '0) begin
                drain_idx_next = '0;
                q_re           = 1'b1;
                q_raddr        = '0;
                state_next     = S_DRN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ARRIVE: begin
        if (ev_cur.enabled) begin
          ev_we = 1'b1;
          if (ev_cur.count != ceq_pkg::COUNT_MAX) begin
            ev_wdata.count = ev_cur.count + ceq_pkg::COUNT_W'(1);
          end
          if (ev_cur.count == '0 && fifo_length < LEN_W'(QUEUE_DEPTH)) begin
            q_we             = 1'b1;
            fifo_length_next = fifo_length + LEN_W'(1);
          end
        end
        state_next = S_IDLE;
      end
      S_DRN_RD: begin
        cur_ev_next = q_rdata;
        ev_re       = 1'b1;
        ev_raddr    = q_rdata[EV_W-1:0];
        state_next  = S_DRN_EMIT;
      end
      S_DRN_EMIT: begin
        if (slot_free) begin
          ev_we          = 1'b1;
          ev_wdata.count = '0;
          if (drn_last) begin
            fifo_length_next = '0;
            state_next       = S_IDLE;
          end else begin
            drain_idx_next = drain_idx + LEN_W'(1);
            q_re           = 1'b1;
            q_raddr        = drain_idx_next[Q_AW-1:0];
            state_next     = S_DRN_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memories: registered reads; no same-entry overlap by construction
  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= ev_wdata;
    end
    if (ev_re) begin
      ev_rdata <= ev_mem[ev_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[fifo_length[Q_AW-1:0]] <= cur_ev;
    end
    if (q_re) begin
      q_rdata <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld  <= '0;
      ev_rvld <= 1'b0;
    end else begin
      if (ev_we) begin
        ev_vld[ev_waddr] <= 1'b1;
      end
      if (ev_re) begin
        ev_rvld <= ev_vld[ev_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fifo_length  <= '0;
      drain_idx    <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      fifo_length <= fifo_length_next;
      drain_idx   <= drain_idx_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_ev <= cur_ev_next;
    if (emit) begin
      result.out_event   <= cur_ev;
      result.occurrences <= ev_cur.count;
      result.fire        <= (ev_cur.count != '0) && ev_cur.enabled;
      result.last        <= drn_last;
    end
  end

endmodule
